// ===== rtl/dual_band_symmetric_fir_macros.svh =====
// ----------------------------------------------------------------------------
// dual_band_symmetric_fir_macros
// assertion macros used by the dual band fir top level
// ----------------------------------------------------------------------------
`ifndef DUAL_BAND_SYMMETRIC_FIR_MACROS_SVH
`define DUAL_BAND_SYMMETRIC_FIR_MACROS_SVH

// same cycle implication
`define DBSF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define DBSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dbsf_pkg
// types, constants and coefficient tables of the dual band fir
// ----------------------------------------------------------------------------
package dbsf_pkg;

  localparam int unsigned COEF_W     = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned NUM_TAPS   = 27;
  localparam int unsigned TAP_W      = 5;
  localparam int unsigned FRAC_SHIFT = 15;
  localparam int unsigned GROWTH_W   = 5;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } fsm_state_e;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [TAP_W-1:0] tap;
  } rd_ctrl_t;

  // beta band, coefficient per tap, symmetric pairs unfolded
  localparam logic signed [COEF_W-1:0] BETA_COEF [NUM_TAPS] = '{
    16'sd334,    16'sd1153,   16'sd775,    -16'sd2639,  -16'sd6095,
    -16'sd3382,  16'sd7289,   16'sd15549,  16'sd8170,   -16'sd12686,
    -16'sd25777, -16'sd13271, 16'sd15302,  16'sd15135,  16'sd15302,
    -16'sd13271, -16'sd25777, -16'sd12686, 16'sd8170,   16'sd15549,
    16'sd7289,   -16'sd3382,  -16'sd6095,  -16'sd2639,  16'sd775,
    16'sd1153,   16'sd334
  };

  // mu band, 23 taps, zero beyond
  localparam logic signed [COEF_W-1:0] MU_COEF [NUM_TAPS] = '{
    16'sd9453,   -16'sd1255,  -16'sd3809,  -16'sd7204,  -16'sd10221,
    -16'sd11525, -16'sd10079, -16'sd5625,  16'sd1038,   16'sd8175,
    16'sd13618,  16'sd7836,   16'sd13618,  16'sd8175,   16'sd1038,
    -16'sd5625,  -16'sd10079, -16'sd11525, -16'sd10221, -16'sd7204,
    -16'sd3809,  -16'sd1255,  16'sd9453,   16'sd0,      16'sd0,
    16'sd0,      16'sd0
  };

endpackage

// ===== rtl/dbsf_ring.sv =====
// ----------------------------------------------------------------------------
// dbsf_ring
// sample ring memory with write pointer, fill count and tap read port
// ----------------------------------------------------------------------------
module dbsf_ring #(
  parameter int unsigned RING_DEPTH   = 32,
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [SAMPLE_WIDTH-1:0] wr_data_i,
  input  dbsf_pkg::rd_ctrl_t      rd_ctrl_i,
  output logic [SAMPLE_WIDTH-1:0] rd_data_o
);
  import dbsf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);

  logic [SAMPLE_WIDTH-1:0] mem [RING_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_q;
  logic                    tap_ok_q, tap_ok_d;
  logic [ADDR_W-1:0]       wp_q, wp_d;
  logic [TAP_W-1:0]        fill_q, fill_d;
  logic [ADDR_W:0]         back_sum;
  logic [ADDR_W-1:0]       rd_addr;

  // the pointer has already moved past the newest sample when the taps are read
  always_comb begin
    back_sum = {1'b0, wp_q} + (ADDR_W+1)'(RING_DEPTH) - (ADDR_W+1)'(rd_ctrl_i.tap)
               - (ADDR_W+1)'(1);
    if (back_sum >= (ADDR_W+1)'(RING_DEPTH)) begin
      rd_addr = ADDR_W'(back_sum - (ADDR_W+1)'(RING_DEPTH));
    end else begin
      rd_addr = back_sum[ADDR_W-1:0];
    end
  end

  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    tap_ok_d = tap_ok_q;
    if (wr_en_i) begin
      wp_d = (wp_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != TAP_W'(NUM_TAPS)) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (rd_ctrl_i.vld) begin
      tap_ok_d = rd_ctrl_i.tap < fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      fill_q   <= '0;
      tap_ok_q <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      tap_ok_q <= tap_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_ctrl_i.vld) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries not written since reset read as zero
  assign rd_data_o = tap_ok_q ? rd_q : '0;

endmodule

// ===== rtl/dbsf_mac.sv =====
// ----------------------------------------------------------------------------
// dbsf_mac
// two band multiply accumulate over the taps, with output scaling
// ----------------------------------------------------------------------------
module dbsf_mac #(
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dbsf_pkg::rd_ctrl_t                rd_ctrl_i,
  input  logic [SAMPLE_WIDTH-1:0]           rd_data_i,
  output logic                              done_o,
  output logic signed [dbsf_pkg::OUT_W-1:0] mu_o,
  output logic signed [dbsf_pkg::OUT_W-1:0] beta_o
);
  import dbsf_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_W + 1;
  localparam int unsigned SUM_W  = PROD_W + GROWTH_W;
  localparam int unsigned ACC_W  = (SUM_W > 32) ? SUM_W : 32;
  localparam int unsigned EXT_W  = ACC_W - PROD_W;
  localparam int unsigned SH_W   = ACC_W - FRAC_SHIFT;

  localparam logic signed [SH_W-1:0] OUT_MAX = SH_W'(32767);
  localparam logic signed [SH_W-1:0] OUT_MIN = SH_W'(-32768);

  rd_ctrl_t                  s1_q, s2_q;
  logic signed [SAMPLE_WIDTH:0] data_s;
  logic signed [PROD_W-1:0]  mu_prod_d, beta_prod_d, mu_prod_q, beta_prod_q;
  logic signed [ACC_W-1:0]   mu_acc_q, beta_acc_q, mu_acc_d, beta_acc_d;
  logic                      done_q, done_d;
  logic signed [SH_W-1:0]    mu_sh, beta_sh;

  assign data_s      = $signed({1'b0, rd_data_i});
  assign mu_prod_d   = data_s * MU_COEF[s1_q.tap];
  assign beta_prod_d = data_s * BETA_COEF[s1_q.tap];

  always_comb begin
    mu_acc_d   = mu_acc_q;
    beta_acc_d = beta_acc_q;
    done_d     = done_q;
    if (rd_ctrl_i.vld && rd_ctrl_i.first) begin
      done_d = 1'b0;
    end
    if (s2_q.vld) begin
      if (s2_q.first) begin
        mu_acc_d   = {{EXT_W{mu_prod_q[PROD_W-1]}}, mu_prod_q};
        beta_acc_d = {{EXT_W{beta_prod_q[PROD_W-1]}}, beta_prod_q};
      end else begin
        mu_acc_d   = mu_acc_q + {{EXT_W{mu_prod_q[PROD_W-1]}}, mu_prod_q};
        beta_acc_d = beta_acc_q + {{EXT_W{beta_prod_q[PROD_W-1]}}, beta_prod_q};
      end
      if (s2_q.last) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= rd_ctrl_i;
      s2_q   <= s1_q;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mu_prod_q   <= mu_prod_d;
    beta_prod_q <= beta_prod_d;
    mu_acc_q    <= mu_acc_d;
    beta_acc_q  <= beta_acc_d;
  end

  // floor shift then clamp to the output range
  assign mu_sh   = mu_acc_q[ACC_W-1:FRAC_SHIFT];
  assign beta_sh = beta_acc_q[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    if (mu_sh > OUT_MAX) begin
      mu_o = OUT_W'(OUT_MAX);
    end else if (mu_sh < OUT_MIN) begin
      mu_o = OUT_W'(OUT_MIN);
    end else begin
      mu_o = mu_sh[OUT_W-1:0];
    end
    if (beta_sh > OUT_MAX) begin
      beta_o = OUT_W'(OUT_MAX);
    end else if (beta_sh < OUT_MIN) begin
      beta_o = OUT_W'(OUT_MIN);
    end else begin
      beta_o = beta_sh[OUT_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/dbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbsf_ctrl
// sequencer: takes a sample, walks the taps, hands the result on
// ----------------------------------------------------------------------------
module dbsf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 mac_done_i,
  input  logic                 out_free_i,
  output logic                 in_stall_o,
  output logic                 wr_en_o,
  output logic                 out_load_o,
  output dbsf_pkg::rd_ctrl_t   rd_ctrl_o,
  output dbsf_pkg::fsm_state_e state_o
);
  import dbsf_pkg::*;

  fsm_state_e       state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (tap_q == LAST_TAP) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done_i && out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    wr_en_o    = 1'b0;
    out_load_o = 1'b0;
    rd_ctrl_o  = '0;
    tap_d      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        wr_en_o    = in_valid_i;
      end
      ST_READ: begin
        rd_ctrl_o.vld   = 1'b1;
        rd_ctrl_o.first = (tap_q == '0);
        rd_ctrl_o.last  = (tap_q == LAST_TAP);
        rd_ctrl_o.tap   = tap_q;
        tap_d           = tap_q + 1'b1;
      end
      ST_DRAIN: begin
        out_load_o = mac_done_i && out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  assign state_o = state_q;

endmodule

// ===== rtl/dual_band_symmetric_fir.sv =====
// ----------------------------------------------------------------------------
// dual_band_symmetric_fir
// mu and beta band symmetric fir for one converter channel
// ----------------------------------------------------------------------------
// input channel: sample_i with in_valid_i, in_stall_o; one transfer per sample.
// output channel: mu_band_value_o and beta_band_value_o with out_valid_o,
// out_stall_i; one transfer per sample, in sample order.
// each sample is written into a ring memory, then the 27 taps are read one a
// cycle through the single read port and multiplied against both coefficient
// tables in parallel, then summed, floor shifted by 15 and clamped.
// in_stall_o stays high from the input transfer until the result is loaded
// into the output register, so no new sample is taken before the last one is
// through. the sample rate is set by the one memory read per tap.
// the output register holds a result while out_stall_i is high; a new sample
// is still taken, and its result waits in the accumulators until the register
// is free.
// reset clears the pointer, the fill count and all control state; ring entries
// not written since reset read as zero, and no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "dual_band_symmetric_fir_macros.svh"

module dual_band_symmetric_fir #(
  parameter int unsigned RING_DEPTH   = 32,
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]           sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dbsf_pkg::OUT_W-1:0] mu_band_value_o,
  output logic signed [dbsf_pkg::OUT_W-1:0] beta_band_value_o
);
  import dbsf_pkg::*;

  rd_ctrl_t                 rd_ctrl;
  fsm_state_e               state;
  logic                     wr_en, out_load, out_free, mac_done;
  logic [SAMPLE_WIDTH-1:0]  rd_data;
  logic signed [OUT_W-1:0]  mu_val, beta_val;
  logic                     out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]  mu_q, beta_q;

  assign out_free = !out_valid_q || !out_stall_i;

  dbsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mac_done_i (mac_done),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .wr_en_o    (wr_en),
    .out_load_o (out_load),
    .rd_ctrl_o  (rd_ctrl),
    .state_o    (state)
  );

  dbsf_ring #(
    .RING_DEPTH   (RING_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (sample_i),
    .rd_ctrl_i (rd_ctrl),
    .rd_data_o (rd_data)
  );

  dbsf_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_ctrl_i (rd_ctrl),
    .rd_data_i (rd_data),
    .done_o    (mac_done),
    .mu_o      (mu_val),
    .beta_o    (beta_val)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mu_q   <= mu_val;
      beta_q <= beta_val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mu_band_value_o   = mu_q;
  assign beta_band_value_o = beta_q;

  // a finished result never overwrites one still waiting
  `DBSF_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, out_load,
                    !(out_valid_q && out_stall_i), "result overwritten while stalled")
  // after a sample transfer the tap walk runs and no further sample is taken
  `DBSF_ASSERT_NEXT(a_walk_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o,
                    in_stall_o && rd_ctrl.vld && rd_ctrl.first, "tap walk did not start")
  // the result is only handed on once the accumulators hold the last tap
  `DBSF_ASSERT_SAME(a_load_when_done, clk_i, rst_ni, out_load,
                    mac_done && state == ST_DRAIN && !rd_ctrl.vld, "early result load")

endmodule
